>>> src/dsfp_pkg.sv
// shared types and constants for the dust sensor frame parser
package dsfp_pkg;

   localparam logic [7:0] HEADER_BYTE    = 8'h16;
   localparam int         VALUE_HIGH_POS = 3;
   localparam int         VALUE_LOW_POS  = 4;
   localparam int         LENGTH_OUT_W   = 6;
   localparam int         VALUE_W        = 16;

   typedef enum logic [3:0] {
      PH_HUNT  = 4'b0001,
      PH_LEN   = 4'b0010,
      PH_DATA  = 4'b0100,
      PH_CHECK = 4'b1000
   } phase_type;

   typedef struct packed {
      logic                    checksum_ok;
      logic [LENGTH_OUT_W-1:0] payload_length;
      logic [VALUE_W-1:0]      particle_value;
   } result_type;

   typedef struct packed {
      logic       valid;
      result_type data;
   } emit_type;

endpackage

>>> src/dsfp_channel_if.sv
// request and response channel interfaces
interface dsfp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink (input valid, input rx_byte, output ready);
endinterface

interface dsfp_rsp_if;
   logic                              valid;
   logic                              ready;
   logic                              checksum_ok;
   logic [dsfp_pkg::LENGTH_OUT_W-1:0] payload_length;
   logic [dsfp_pkg::VALUE_W-1:0]      particle_value;

   modport source (output valid, output checksum_ok, output payload_length,
                   output particle_value, input ready);
   modport sink (input valid, input checksum_ok, input payload_length,
                 input particle_value, output ready);
endinterface

>>> src/dsfp_parser.sv
// frame state machine with running sum and value byte capture
module dsfp_parser #(
   parameter int MAX_PAYLOAD = 32
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               byte_accept,
   input  logic [7:0]         rx_byte,
   output logic               at_check,
   output dsfp_pkg::emit_type emit
);

   localparam int LEN_W = $clog2(MAX_PAYLOAD + 1);
   localparam logic [7:0]       MAX_LEN  = 8'(MAX_PAYLOAD);
   localparam logic [LEN_W-1:0] POS_HIGH = LEN_W'(dsfp_pkg::VALUE_HIGH_POS);
   localparam logic [LEN_W-1:0] POS_LOW  = LEN_W'(dsfp_pkg::VALUE_LOW_POS);

   dsfp_pkg::phase_type phase_ff, phase_in;
   logic [7:0]       sum_ff, sum_in;
   logic [LEN_W-1:0] length_ff, length_in;
   logic [LEN_W-1:0] pos_ff, pos_in;
   logic [7:0]       high_ff, high_in;
   logic [7:0]       low_ff, low_in;
   logic [7:0]       sum_add;
   logic [LEN_W-1:0] pos_next;
   logic [7:0]       length_wide;

   assign sum_add     = sum_ff + rx_byte;
   assign pos_next    = pos_ff + LEN_W'(1);
   assign length_wide = 8'(length_ff);
   assign at_check    = (phase_ff == dsfp_pkg::PH_CHECK);

   always_comb begin
      phase_in  = phase_ff;
      sum_in    = sum_ff;
      length_in = length_ff;
      pos_in    = pos_ff;
      high_in   = high_ff;
      low_in    = low_ff;
      if (byte_accept) begin
         unique case (phase_ff)
            dsfp_pkg::PH_HUNT: begin
               sum_in = rx_byte;
               if (rx_byte == dsfp_pkg::HEADER_BYTE) phase_in = dsfp_pkg::PH_LEN;
            end
            dsfp_pkg::PH_LEN: begin
               sum_in = sum_add;
               if (rx_byte <= MAX_LEN) begin
                  length_in = rx_byte[LEN_W-1:0];
                  pos_in    = '0;
                  phase_in  = (rx_byte != 8'd0) ? dsfp_pkg::PH_DATA : dsfp_pkg::PH_CHECK;
               end else begin
                  phase_in = dsfp_pkg::PH_HUNT;
               end
            end
            dsfp_pkg::PH_DATA: begin
               sum_in = sum_add;
               if (pos_ff == POS_HIGH) high_in = rx_byte;
               else if (pos_ff == POS_LOW) low_in = rx_byte;
               pos_in = pos_next;
               if (pos_next >= length_ff) phase_in = dsfp_pkg::PH_CHECK;
            end
            dsfp_pkg::PH_CHECK: begin
               sum_in   = sum_add;
               phase_in = dsfp_pkg::PH_HUNT;
            end
            default: begin
               phase_in = dsfp_pkg::PH_HUNT;
            end
         endcase
      end
   end

   // result is formed in the same cycle the checksum byte arrives
   always_comb begin
      emit.valid                    = byte_accept && at_check;
      emit.data.checksum_ok         = (sum_add == 8'd0);
      emit.data.payload_length      = length_wide[dsfp_pkg::LENGTH_OUT_W-1:0];
      emit.data.particle_value      = {high_ff, low_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= dsfp_pkg::PH_HUNT;
         sum_ff    <= '0;
         length_ff <= '0;
         pos_ff    <= '0;
         high_ff   <= '0;
         low_ff    <= '0;
      end else begin
         phase_ff  <= phase_in;
         sum_ff    <= sum_in;
         length_ff <= length_in;
         pos_ff    <= pos_in;
         high_ff   <= high_in;
         low_ff    <= low_in;
      end
   end

endmodule

>>> src/dsfp_rsp_reg.sv
// output register holding one finished result until taken
module dsfp_rsp_reg (
   input  logic                 clock,
   input  logic                 reset,
   input  dsfp_pkg::emit_type   emit,
   input  logic                 out_ready,
   output logic                 out_valid,
   output dsfp_pkg::result_type out_data
);

   logic                 valid_ff, valid_in;
   dsfp_pkg::result_type data_ff, data_in;

   always_comb begin
      valid_in = valid_ff && !out_ready;
      data_in  = data_ff;
      if (emit.valid) begin
         valid_in = 1'b1;
         data_in  = emit.data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

>>> src/dust_sensor_frame_parser_core.sv
// dust sensor frame parser top level
//
//   channel  dir  payload                                      role
//   req_if   in   rx_byte[7:0]                                 one serial byte
//   rsp_if   out  checksum_ok, payload_length[5:0],            one per frame
//                 particle_value[15:0]
//
// one byte per cycle except when a checksum byte stalls; the result appears in the
// cycle after its checksum byte is taken, held in the single output register.
// synchronous reset returns the parser to header hunting with cleared state.
// while a result waits, bytes that finish no frame are still taken; only a
// checksum byte stalls until the output register drains.
module dust_sensor_frame_parser_core #(
   parameter int MAX_PAYLOAD = 32
) (
   input logic        clock,
   input logic        reset,
   dsfp_req_if.sink   req_if,
   dsfp_rsp_if.source rsp_if
);

   logic                 at_check;
   logic                 byte_accept;
   logic                 out_valid;
   dsfp_pkg::emit_type   emit;
   dsfp_pkg::result_type out_data;

   assign req_if.ready = !at_check || !out_valid || rsp_if.ready;
   assign byte_accept  = req_if.valid && req_if.ready;

   dsfp_parser #(
      .MAX_PAYLOAD(MAX_PAYLOAD)
   ) u_parser (
      .clock      (clock),
      .reset      (reset),
      .byte_accept(byte_accept),
      .rx_byte    (req_if.rx_byte),
      .at_check   (at_check),
      .emit       (emit)
   );

   dsfp_rsp_reg u_rsp_reg (
      .clock    (clock),
      .reset    (reset),
      .emit     (emit),
      .out_ready(rsp_if.ready),
      .out_valid(out_valid),
      .out_data (out_data)
   );

   assign rsp_if.valid          = out_valid;
   assign rsp_if.checksum_ok    = out_data.checksum_ok;
   assign rsp_if.payload_length = out_data.payload_length;
   assign rsp_if.particle_value = out_data.particle_value;

endmodule

>>> tb/dust_sensor_frame_parser_core_tb.sv
// self-checking testbench for the dust sensor frame parser: directed table, then random frames
module dust_sensor_frame_parser_core_tb;

   localparam int FRAME_MAX      = 32;
   localparam int DIRECTED_ROWS  = 24;
   localparam int RANDOM_BYTES   = 800;
   localparam int WATCHDOG_LIMIT = 1000;
   localparam int DRAIN_CYCLES   = 10;

   typedef struct packed {
      logic [7:0]           rx;
      logic                 pinned;
      dsfp_pkg::result_type frame;
   } stim_row_type;

   logic clock;
   logic reset;

   dsfp_req_if req_ch ();
   dsfp_rsp_if rsp_ch ();

   dust_sensor_frame_parser_core #(
      .MAX_PAYLOAD(FRAME_MAX)
   ) uut (
      .clock (clock),
      .reset (reset),
      .req_if(req_ch),
      .rsp_if(rsp_ch)
   );

   // parser state as seen by the predictor
   dsfp_pkg::phase_type parse_phase;
   logic [7:0] frame_sum;
   logic [7:0] frame_len;
   logic [7:0] payload_pos;
   logic [7:0] value_high;
   logic [7:0] value_low;

   dsfp_pkg::result_type expected_frames [$];
   int         mismatch_count;
   int         accepted_bytes;
   int         stalled_cycles;
   logic       calm_window;

   // a stretch in which neither side idles
   assign calm_window = accepted_bytes >= 300 && accepted_bytes < 450;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      reset = 1'b1;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
   end

   // advance the parser by one byte; returns 1 when the byte closes a frame
   function automatic bit parse_sensor_byte(input logic [7:0] b,
                                            output dsfp_pkg::result_type frame);
      frame = '0;
      case (parse_phase)
         dsfp_pkg::PH_HUNT: begin
            frame_sum = b;
            if (b == dsfp_pkg::HEADER_BYTE) parse_phase = dsfp_pkg::PH_LEN;
         end
         dsfp_pkg::PH_LEN: begin
            frame_sum = frame_sum + b;
            if (b <= FRAME_MAX) begin
               frame_len   = b;
               payload_pos = '0;
               parse_phase = (b != 8'd0) ? dsfp_pkg::PH_DATA : dsfp_pkg::PH_CHECK;
            end else begin
               parse_phase = dsfp_pkg::PH_HUNT;
            end
         end
         dsfp_pkg::PH_DATA: begin
            frame_sum = frame_sum + b;
            if (payload_pos == dsfp_pkg::VALUE_HIGH_POS) value_high = b;
            else if (payload_pos == dsfp_pkg::VALUE_LOW_POS) value_low = b;
            payload_pos = payload_pos + 8'd1;
            if (payload_pos >= frame_len) parse_phase = dsfp_pkg::PH_CHECK;
         end
         default: begin
            frame_sum   = frame_sum + b;
            parse_phase = dsfp_pkg::PH_HUNT;
            frame.checksum_ok    = (frame_sum == 8'd0);
            frame.payload_length = frame_len[dsfp_pkg::LENGTH_OUT_W-1:0];
            frame.particle_value = {value_high, value_low};
            return 1'b1;
         end
      endcase
      return 1'b0;
   endfunction

   // called at a falling edge, returns at the falling edge after the transaction
   task automatic send_byte(input logic [7:0] value, input logic pinned,
                            input dsfp_pkg::result_type pinned_frame);
      dsfp_pkg::result_type frame;
      while (!calm_window && $urandom_range(99) < 18) begin
         req_ch.valid = 1'b0;
         @(negedge clock);
      end
      req_ch.valid   = 1'b1;
      req_ch.rx_byte = value;
      do @(posedge clock); while (!req_ch.ready);
      accepted_bytes++;
      if (parse_sensor_byte(value, frame))
         expected_frames.push_back(pinned ? pinned_frame : frame);
      @(negedge clock);
   endtask

   initial begin : stimulus
      stim_row_type directed_rows [0:DIRECTED_ROWS-1];
      logic [7:0] frame_bytes [$];
      logic [7:0] frame_total;
      logic [7:0] len_byte;
      logic [7:0] data_byte;
      int         pick;
      int         keep_len;

      req_ch.valid   = 1'b0;
      req_ch.rx_byte = '0;
      parse_phase    = dsfp_pkg::PH_HUNT;
      frame_sum      = '0;
      frame_len      = '0;
      payload_pos    = '0;
      value_high     = '0;
      value_low      = '0;
      mismatch_count = 0;
      accepted_bytes = 0;

      directed_rows = '{
         // noise while hunting
         '{8'h00, 1'b0, '0}, '{8'hFF, 1'b0, '0},
         // zero-length frame right after reset, value still cleared
         '{8'h16, 1'b0, '0}, '{8'h00, 1'b0, '0},
         '{8'hEA, 1'b1, '{1'b1, 6'd0, 16'h0000}},
         // lengths above the limit drop back to hunting
         '{8'h16, 1'b0, '0}, '{8'h21, 1'b0, '0},
         '{8'h16, 1'b0, '0}, '{8'hFF, 1'b0, '0},
         // zero-length frame with a bad checksum
         '{8'h16, 1'b0, '0}, '{8'h00, 1'b0, '0},
         '{8'h00, 1'b1, '{1'b0, 6'd0, 16'h0000}},
         // five payload bytes carry the value
         '{8'h16, 1'b0, '0}, '{8'h05, 1'b0, '0}, '{8'h01, 1'b0, '0},
         '{8'h02, 1'b0, '0}, '{8'h03, 1'b0, '0}, '{8'hFF, 1'b0, '0},
         '{8'h00, 1'b0, '0},
         '{8'hE0, 1'b1, '{1'b1, 6'd5, 16'hFF00}},
         // short frame keeps the stale value
         '{8'h16, 1'b0, '0}, '{8'h01, 1'b0, '0}, '{8'hAA, 1'b0, '0},
         '{8'h3F, 1'b1, '{1'b1, 6'd1, 16'hFF00}}
      };

      wait (!reset);
      @(negedge clock);

      for (int i = 0; i < DIRECTED_ROWS; i++)
         send_byte(directed_rows[i].rx, directed_rows[i].pinned, directed_rows[i].frame);

      // hold off until every frame so far has come out
      req_ch.valid = 1'b0;
      while (expected_frames.size() != 0) @(negedge clock);

      while (accepted_bytes < DIRECTED_ROWS + RANDOM_BYTES) begin
         if ($urandom_range(99) < 3) begin
            req_ch.valid = 1'b0;
            while (expected_frames.size() != 0) @(negedge clock);
         end
         frame_bytes = {};
         if ($urandom_range(99) < 25)
            repeat ($urandom_range(3, 1)) frame_bytes.push_back(8'($urandom_range(255)));

         pick = $urandom_range(99);
         if (pick < 8) len_byte = 8'($urandom_range(255, FRAME_MAX + 1));
         else if (pick < 14) len_byte = 8'(FRAME_MAX);
         else if (pick < 22) len_byte = 8'h00;
         else if (pick < 32) len_byte = 8'($urandom_range(FRAME_MAX - 1, 9));
         else len_byte = 8'($urandom_range(8, 1));

         frame_bytes.push_back(dsfp_pkg::HEADER_BYTE);
         frame_bytes.push_back(len_byte);
         if (len_byte <= FRAME_MAX) begin
            frame_total = dsfp_pkg::HEADER_BYTE + len_byte;
            // now and then the frame is cut short and runs into the next one
            keep_len = ($urandom_range(99) < 5) ? int'($urandom_range(len_byte))
                                                : int'(len_byte);
            for (int i = 0; i < keep_len; i++) begin
               data_byte = 8'($urandom_range(255));
               frame_total = frame_total + data_byte;
               frame_bytes.push_back(data_byte);
            end
            if (keep_len == int'(len_byte))
               frame_bytes.push_back(($urandom_range(99) < 80) ? 8'h00 - frame_total
                                                             : 8'($urandom_range(255)));
         end
         foreach (frame_bytes[i]) send_byte(frame_bytes[i], 1'b0, '0);
      end

      req_ch.valid = 1'b0;
      while (expected_frames.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

   always @(negedge clock) rsp_ch.ready = calm_window || ($urandom_range(99) >= 18);

   always @(posedge clock) begin : frame_checker
      dsfp_pkg::result_type got;
      dsfp_pkg::result_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         got = {rsp_ch.checksum_ok, rsp_ch.payload_length, rsp_ch.particle_value};
         if (expected_frames.size() == 0) begin
            mismatch_count++;
            $display("%0t: expected no frame result, actual ok=%0d len=%0d value=%04h",
                     $time, got.checksum_ok, got.payload_length, got.particle_value);
         end else begin
            want = expected_frames.pop_front();
            if (got.checksum_ok !== want.checksum_ok ||
                got.payload_length !== want.payload_length ||
                got.particle_value !== want.particle_value) begin
               mismatch_count++;
               $display("%0t: frame result expected ok=%0d len=%0d value=%04h,",
                        $time, want.checksum_ok, want.payload_length, want.particle_value,
                        " actual ok=%0d len=%0d value=%04h",
                        got.checksum_ok, got.payload_length, got.particle_value);
            end
         end
      end
   end

   // no transaction on either side for too long means the block is stuck
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         stalled_cycles <= 0;
      end else if (stalled_cycles >= WATCHDOG_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end else begin
         stalled_cycles <= stalled_cycles + 1;
      end
   end

endmodule
